FILE: src/npq_pkg.sv
// npq_pkg: shared types, constants and the palette ROM for the
// nearest palette quantizer. No dependencies.
package npq_pkg;

  // Field and datapath widths
  localparam int PIXEL_W      = 16;
  localparam int INDEX_W      = 6;
  localparam int DIM_W        = 9;
  localparam int CH_W         = 8;
  localparam int DIST_W       = 18;   // 4 * 255^2 fits in 18 bits
  localparam int ROM_IDX_W    = 8;    // covers palettes up to 256 entries
  localparam int ROM_ENTRIES  = 56;
  localparam int PALETTE_SIZE_DEF = 56;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // RGB888 palette contents
  localparam logic [23:0] PAL_ROM [ROM_ENTRIES] = '{
    24'h666666, 24'h002A88, 24'h1412A7, 24'h3B00A4, 24'h5C007E, 24'h6E0040, 24'h6C0600,
    24'h561D00, 24'h333500, 24'h0B4800, 24'h005200, 24'h004F08, 24'h00404D, 24'h000000,
    24'hADADAD, 24'h155FD9, 24'h4240FF, 24'h7527FE, 24'hA01ACC, 24'hB71E7B, 24'hB53120,
    24'h994E00, 24'h6B6D00, 24'h388700, 24'h0C9300, 24'h008F32, 24'h007C8D, 24'h000000,
    24'hFFFEFF, 24'h64B0FF, 24'h9290FF, 24'hC676FF, 24'hF36AFF, 24'hFE6ECC, 24'hFE8170,
    24'hEA9E22, 24'hBCBE00, 24'h88D800, 24'h5CE430, 24'h45E082, 24'h48CDDE, 24'h4F4F4F,
    24'hFFFEFF, 24'hC0DFFF, 24'hD3D2FF, 24'hE8C8FF, 24'hFBC2FF, 24'hFEC4EA, 24'hFECCC5,
    24'hF7D8A5, 24'hE4E594, 24'hCFEF96, 24'hBDF4AB, 24'hB3ECDC, 24'h000000, 24'h000000
  };

  // Entries past the ROM read as black
  function automatic logic [23:0] npq_rom_read(input logic [ROM_IDX_W-1:0] idx);
    logic [23:0] val;
    val = 24'h000000;
    if (idx < ROM_IDX_W'(ROM_ENTRIES)) begin
      val = PAL_ROM[idx[5:0]];
    end
    return val;
  endfunction

endpackage

FILE: src/npq_if.sv
// npq_if: valid/ready channel interfaces for the pixel input and the
// quantized result. Depends on npq_pkg.
interface npq_pix_if import npq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_rgb565;

  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

interface npq_res_if import npq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] quantized_rgb565;
  logic [INDEX_W-1:0] palette_index;

  modport source (output valid, output quantized_rgb565, output palette_index,
                  input ready);
  modport sink   (input valid, input quantized_rgb565, input palette_index,
                  output ready);
endinterface

FILE: src/nearest_palette_quantizer_core.sv
// Nearest palette quantizer top level: sequencer, distance unit, dimming
// and output register. Depends on npq_pkg and the channels in npq_if.sv.
//
// Each accepted RGB565 beat is widened to RGB888 and compared against the
// palette one entry per clock with the weighted distance dR^2 + 2*dG^2 + dB^2;
// the first entry wins a tie. The winning color is scaled by dim_factor (Q8,
// 256 = full, saturating at 255) and packed back to RGB565 with its index.
// An item passes in turn through the accept in the idle state, the search of
// every palette entry through the single distance and compare unit, and the
// dimming into the output register. The result then waits in that register,
// so a new pixel is accepted while the previous result is still unread; the
// dim step of that next pixel holds until the register has been read.
// dim_factor is written through cfg_we and cfg_data and should only change
// while the block is idle.
module nearest_palette_quantizer_core
  import npq_pkg::*;
#(
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DIM_W-1:0] cfg_data,
  npq_pix_if.sink          pix,
  npq_res_if.source        res
);

  localparam int CNT_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PALETTE_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIM
  } state_t;

  state_t             state;
  logic [DIM_W-1:0]   dim_factor;
  logic [CH_W-1:0]    pix_r, pix_g, pix_b;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   best;
  logic [DIST_W-1:0]  best_d;

  // Distance unit: one palette entry per cycle
  logic [23:0]        ent;
  logic [CH_W-1:0]    dr, dg, db;
  logic [2*CH_W-1:0]  sqr, sqg, sqb;
  logic [DIST_W-1:0]  ent_d;

  assign ent = npq_rom_read(ROM_IDX_W'(idx));

  always_comb begin
    dr    = (pix_r > ent[23:16]) ? pix_r - ent[23:16] : ent[23:16] - pix_r;
    dg    = (pix_g > ent[15:8])  ? pix_g - ent[15:8]  : ent[15:8]  - pix_g;
    db    = (pix_b > ent[7:0])   ? pix_b - ent[7:0]   : ent[7:0]   - pix_b;
    sqr   = dr * dr;
    sqg   = dg * dg;
    sqb   = db * db;
    ent_d = {2'b00, sqr} + {1'b0, sqg, 1'b0} + {2'b00, sqb};
  end

  // Dimming of the chosen entry, saturating at 255
  logic [23:0]           win;
  logic [CH_W+DIM_W-1:0] pr, pg, pb;
  logic [CH_W-1:0]       vr, vg, vb;
  logic [PIXEL_W-1:0]    packed_px;

  assign win = npq_rom_read(ROM_IDX_W'(best));

  always_comb begin
    pr = {{DIM_W{1'b0}}, win[23:16]} * {{CH_W{1'b0}}, dim_factor};
    pg = {{DIM_W{1'b0}}, win[15:8]}  * {{CH_W{1'b0}}, dim_factor};
    pb = {{DIM_W{1'b0}}, win[7:0]}   * {{CH_W{1'b0}}, dim_factor};
    vr = (pr[CH_W+DIM_W-1:16] != '0) ? 8'hFF : pr[15:8];
    vg = (pg[CH_W+DIM_W-1:16] != '0) ? 8'hFF : pg[15:8];
    vb = (pb[CH_W+DIM_W-1:16] != '0) ? 8'hFF : pb[15:8];
    packed_px = {vr[7:3], vg[7:2], vb[7:3]};
  end

  assign pix.ready = (state == ST_IDLE);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_factor <= DIM_RESET;
    end else if (cfg_we) begin
      dim_factor <= cfg_data;
    end
  end

  // Sequencer, search registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      // the dim step reloads the register itself when it is read
      if (res.valid && res.ready && state != ST_DIM) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pix.valid) begin
            pix_r  <= {pix.pixel_rgb565[15:11], 3'b000};
            pix_g  <= {pix.pixel_rgb565[10:5], 2'b00};
            pix_b  <= {pix.pixel_rgb565[4:0], 3'b000};
            idx    <= '0;
            best   <= '0;
            best_d <= '1;
            state  <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // strict compare keeps the first entry on a tie
          if (ent_d < best_d) begin
            best_d <= ent_d;
            best   <= idx;
          end
          if (idx == LAST_IDX) begin
            state <= ST_DIM;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DIM: begin
          // wait here while an earlier result is still unread
          if (!res.valid || res.ready) begin
            res.valid            <= 1'b1;
            res.quantized_rgb565 <= packed_px;
            res.palette_index    <= INDEX_W'(best);
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (idx <= LAST_IDX))
    else $error("search index past palette end");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == ST_SEARCH))
    else $error("accepted pixel did not start a search");

  a_result_from_dim: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == ST_DIM))
    else $error("result appeared outside the dim step");
`endif

endmodule

FILE: bench/npq_color_checker.sv
`timescale 1ns / 1ps
// npq_color_checker: watches the pixel and result channels of the quantizer,
// predicts each result from its own palette copy and compares beats in order.
// Depends on npq_pkg and the channel interfaces in npq_if.sv.
module npq_color_checker
  import npq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DIM_W-1:0] cfg_data,
  npq_pix_if               pix,
  npq_res_if               res,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] color;
    logic [INDEX_W-1:0] index;
  } quant_t;

  localparam int NUM_COLORS = 56;
  localparam logic [DIM_W-1:0] FULL_BRIGHT = 9'd256;

  // Private copy of the RGB888 palette
  localparam logic [23:0] COLORS [NUM_COLORS] = '{
    24'h666666, 24'h002A88, 24'h1412A7, 24'h3B00A4, 24'h5C007E, 24'h6E0040, 24'h6C0600,
    24'h561D00, 24'h333500, 24'h0B4800, 24'h005200, 24'h004F08, 24'h00404D, 24'h000000,
    24'hADADAD, 24'h155FD9, 24'h4240FF, 24'h7527FE, 24'hA01ACC, 24'hB71E7B, 24'hB53120,
    24'h994E00, 24'h6B6D00, 24'h388700, 24'h0C9300, 24'h008F32, 24'h007C8D, 24'h000000,
    24'hFFFEFF, 24'h64B0FF, 24'h9290FF, 24'hC676FF, 24'hF36AFF, 24'hFE6ECC, 24'hFE8170,
    24'hEA9E22, 24'hBCBE00, 24'h88D800, 24'h5CE430, 24'h45E082, 24'h48CDDE, 24'h4F4F4F,
    24'hFFFEFF, 24'hC0DFFF, 24'hD3D2FF, 24'hE8C8FF, 24'hFBC2FF, 24'hFEC4EA, 24'hFECCC5,
    24'hF7D8A5, 24'hE4E594, 24'hCFEF96, 24'hBDF4AB, 24'hB3ECDC, 24'h000000, 24'h000000
  };

  logic [DIM_W-1:0] brightness;
  quant_t           expected_colors [$];

  // Nearest palette entry (first wins a tie), dimmed and packed to RGB565
  function automatic quant_t quantize(input logic [PIXEL_W-1:0] px,
                                      input logic [DIM_W-1:0] dim);
    quant_t      q;
    int          r, g, b, dr, dg, db, d, best, best_d, v;
    logic [23:0] e;
    logic [7:0]  dimmed [3];
    r = int'({px[15:11], 3'b000});
    g = int'({px[10:5], 2'b00});
    b = int'({px[4:0], 3'b000});
    best = 0;
    best_d = 0;
    for (int i = 0; i < NUM_COLORS; i++) begin
      e = COLORS[i];
      dr = r - int'(e[23:16]);
      dg = g - int'(e[15:8]);
      db = b - int'(e[7:0]);
      d = dr * dr + 2 * dg * dg + db * db;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    e = COLORS[best];
    // Q8 scale per channel, saturating above full scale
    for (int k = 0; k < 3; k++) begin
      v = (int'(e[8*(2-k) +: 8]) * int'(dim)) >> 8;
      dimmed[k] = (v > 255) ? 8'hFF : v[7:0];
    end
    q.pixel = px;
    q.color = {dimmed[0][7:3], dimmed[1][7:2], dimmed[2][7:3]};
    q.index = best[INDEX_W-1:0];
    return q;
  endfunction

  // Track the brightness, queue predictions, check result beats in order
  always @(posedge clk) begin
    quant_t want;
    if (rst) begin
      brightness = FULL_BRIGHT;
      expected_colors.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        brightness = cfg_data;
      end
      if (res.valid && res.ready) begin
        checked++;
        if (expected_colors.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result beat color %h index %0d", $realtime,
                     res.quantized_rgb565, res.palette_index);
          end
        end else begin
          want = expected_colors.pop_front();
          if (res.quantized_rgb565 !== want.color || res.palette_index !== want.index) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: pixel %h: expected color %h index %0d, got color %h index %0d",
                       $realtime, want.pixel, want.color, want.index,
                       res.quantized_rgb565, res.palette_index);
            end
          end
        end
      end
      if (pix.valid && pix.ready) begin
        expected_colors.push_back(quantize(pix.pixel_rgb565, brightness));
      end
    end
    pending = expected_colors.size();
  end

endmodule

FILE: bench/tb_nearest_palette_quantizer_core.sv
`timescale 1ns / 1ps
// tb_nearest_palette_quantizer_core: pixel stimulus, result back-pressure and
// brightness writes for the quantizer; checking sits in npq_color_checker.
// Depends on npq_pkg, npq_if.sv, the core and npq_color_checker.
module tb_nearest_palette_quantizer_core;
  import npq_pkg::*;

  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 69;
  localparam int DRAIN_CYCLES    = 80;

  // Brightness settings; the last phase picks one at random
  localparam logic [DIM_W-1:0] DIM_STEPS [PHASES-1] = '{
    9'd0, 9'd511, 9'd128, 9'd257, 9'd1, 9'd255, 9'd256
  };

  // Channel extremes, single bits, grays and a duplicated palette color
  localparam logic [PIXEL_W-1:0] DIRECTED_PIXELS [20] = '{
    16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 16'h5555,
    16'h0001, 16'h0020, 16'h0800, 16'h8000, 16'h0400, 16'h7FFF, 16'hFFFE,
    16'h632C, 16'h4A69, 16'hAD75, 16'hFFDF, 16'h8410, 16'h7BEF
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [DIM_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               checked;
  int               sent;
  int               settings;

  npq_pix_if pix_ch ();
  npq_res_if res_ch ();

  nearest_palette_quantizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pix      (pix_ch),
    .res      (res_ch)
  );

  npq_color_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .pix        (pix_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Result back-pressure: stretches of always ready, coin flips, long stalls and mostly ready
  initial begin
    int mode;
    int left;
    res_ch.ready = 1'b0;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(5, 120);
      end
      left--;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 7) == 0);
        default: res_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // One pixel beat; returns at the accepting edge
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    @(negedge clk);
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_rgb565 <= px;
    do @(posedge clk); while (!pix_ch.ready);
    sent++;
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Drain all results, let the core settle, then write the brightness
  task automatic write_brightness(input logic [DIM_W-1:0] value);
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly uniform pixels, some with every channel at zero or full scale
  function automatic logic [PIXEL_W-1:0] pick_pixel();
    logic [4:0] r, b;
    logic [5:0] g;
    if ($urandom_range(0, 3) == 0) begin
      r = $urandom_range(0, 1) ? 5'h1F : 5'h00;
      g = $urandom_range(0, 1) ? 6'h3F : 6'h00;
      b = $urandom_range(0, 1) ? 5'h1F : 5'h00;
      return {r, g, b};
    end
    return PIXEL_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int left;
    int burst;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_rgb565 = '0;
    sent = 0;
    settings = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels at the reset brightness, back to back
    foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);

    // Random phases, each under its own brightness
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES - 1) write_brightness(DIM_STEPS[p]);
      else write_brightness(DIM_W'($urandom_range(0, 511)));
      left = BEATS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) send_pixel(pick_pixel());
        left -= burst;
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 20));
      end
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d pixel beats under %0d brightness settings incl. reset value",
             sent, settings + 1);
    $display("%0d result beats compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
